### design/pwft_pkg.sv
`default_nettype none

package pwft_pkg;

    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 6;
    localparam int BIT_W           = 3;
    localparam int BASE_W          = 5;
    localparam int REP_W           = 8;
    localparam int TICK_W          = 10;
    localparam int CFG_IDX_W       = 8;
    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [BYTE_W-1:0] HEADER_BASE   = 8'hA0;
    localparam logic [BASE_W-1:0] DEFAULT_UNIT  = 5'd20;
    localparam logic [BASE_W-1:0] RESET_BASE    = 5'd20;
    localparam logic [REP_W-1:0]  RESET_REPEAT  = 8'd2;

    // pulse length factors, in units of a
    localparam logic [BASE_W-1:0] F_ONE       = 5'd1;
    localparam logic [BASE_W-1:0] F_THREE     = 5'd3;
    localparam logic [BASE_W-1:0] F_END_LOW   = 5'd4;
    localparam logic [BASE_W-1:0] F_END_HIGH  = 5'd20;
    localparam logic [BASE_W-1:0] F_SYNC_HIGH = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 8'd1;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_SEND = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC  = 3'd1,
        PH_HEAD  = 3'd2,
        PH_HINV  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        SH_HOLD,
        SH_SHL,
        SH_HEADER,
        SH_HEADER_INV,
        SH_MEM,
        SH_CHECK,
        SH_ZERO
    } shift_op_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC
    } idx_op_t;

    typedef enum logic [2:0] {
        T_HOLD,
        T_DEC,
        T_HIGH,
        T_LOW,
        T_STOP
    } time_op_t;

    typedef enum logic [1:0] {
        PULSE_SYNC,
        PULSE_END,
        PULSE_BIT
    } pulse_t;

    typedef enum logic [1:0] {
        REP_HOLD,
        REP_LOAD,
        REP_DEC
    } rep_op_t;

    typedef struct packed {
        shift_op_t shift_op;
        idx_op_t   bit_op;
        idx_op_t   byte_op;
        idx_op_t   count_op;
        time_op_t  time_op;
        pulse_t    pulse;
        rep_op_t   rep_op;
        logic      mem_we;
        logic      check_we;
        logic      rd_next;
    } cmd_t;

    typedef struct packed {
        logic expire;
        logic level_high;
        logic bit_last;
        logic more_bytes;
        logic rep_more;
        logic count_zero;
        logic count_full;
    } stat_t;

endpackage

`default_nettype wire

### design/pulse_width_frame_transmitter_unit.sv
`default_nettype none

// Pulse-width coded ASK frame transmitter.
// Input channel (s_*): one item per command. s_mode selects tick (advance time
// by one 10 us tick), load (append s_data to the payload buffer) or send (start
// a frame, s_data is the check byte). Each frame repeat is a sync pulse, header,
// inverted header, payload and check byte, MSB first; an end pulse follows.
// Result channel (m_*): exactly one item per input item: the pin level after
// it, whether a frame is in flight, and whether a load or send was dropped.
// Config channel (cfg_*): index 0 is the unit width, index 1 the repeat count;
// always ready, write only while no item is outstanding.
// An item's result is registered and presented the cycle after it is accepted.
// Throughput: one item per cycle while the receiver takes results; the whole
// step (controller decision plus one datapath update) finishes in the accept
// cycle, so the only limit is the single output register.
// Receiver stall: the result register holds, s_ready drops until it drains.
// Reset (aresetn low, synchronous): idle, pin low, buffer empty, registers at
// their defaults (width 20, two repeats). The payload buffer is not cleared;
// only entries written since the last frame are ever read.

module pulse_width_frame_transmitter_unit
    import pwft_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_mode,
    input  wire logic [BYTE_W-1:0]    s_data,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_pin_level,
    output logic                      m_busy_res,
    output logic                      m_dropped,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    logic  step;
    logic  busy_next;
    logic  drop;
    logic  level_next;

    logic  m_valid_reg;
    logic  pin_reg;
    logic  busy_reg;
    logic  dropped_reg;

    // output register parts the two sides; take a new item while it drains
    assign s_ready   = !m_valid_reg || m_ready;
    assign step      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    pwft_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .mode      (s_mode),
        .stat      (stat),
        .cmd       (cmd),
        .busy_next (busy_next),
        .drop      (drop)
    );

    pwft_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_data    (s_data),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .level_next (level_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (step) begin
            pin_reg     <= level_next;
            busy_reg    <= busy_next;
            dropped_reg <= drop;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pin_level = pin_reg;
    assign m_busy_res  = busy_reg;
    assign m_dropped   = dropped_reg;

endmodule

`default_nettype wire

### design/pwft_ctrl.sv
`default_nettype none

module pwft_ctrl
    import pwft_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [1:0] mode,
    input  wire stat_t      stat,
    output cmd_t            cmd,
    output logic            busy_next,
    output logic            drop
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   busy;

    function automatic pulse_t pulse_of(input phase_t ph);
        pulse_t p;
        begin
            p = PULSE_BIT;
            if (ph == PH_SYNC) p = PULSE_SYNC;
            else if (ph == PH_END) p = PULSE_END;
            return p;
        end
    endfunction

    assign busy      = (phase_reg != PH_IDLE);
    assign busy_next = (phase_next != PH_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        drop         = 1'b0;
        cmd.shift_op = SH_HOLD;
        cmd.bit_op   = IDX_HOLD;
        cmd.byte_op  = IDX_HOLD;
        cmd.count_op = IDX_HOLD;
        cmd.time_op  = T_HOLD;
        cmd.pulse    = PULSE_BIT;
        cmd.rep_op   = REP_HOLD;
        cmd.mem_we   = 1'b0;
        cmd.check_we = 1'b0;
        cmd.rd_next  = (phase_reg == PH_DATA);
        if (step) begin
            unique case (mode_t'(mode))
                MODE_TICK: begin
                    if (busy) begin
                        if (!stat.expire) begin
                            cmd.time_op = T_DEC;
                        end else if (stat.level_high) begin
                            cmd.time_op = T_LOW;
                            cmd.pulse   = pulse_of(phase_reg);
                        end else begin
                            unique case (phase_reg)
                                PH_SYNC: begin
                                    phase_next   = PH_HEAD;
                                    cmd.shift_op = SH_HEADER;
                                    cmd.bit_op   = IDX_CLR;
                                    cmd.time_op  = T_HIGH;
                                end
                                PH_END: begin
                                    phase_next   = PH_IDLE;
                                    cmd.time_op  = T_STOP;
                                    cmd.count_op = IDX_CLR;
                                end
                                default: begin
                                    cmd.shift_op = SH_SHL;
                                    cmd.bit_op   = IDX_INC;
                                    cmd.time_op  = T_HIGH;
                                    if (stat.bit_last) begin
                                        unique case (phase_reg)
                                            PH_HEAD: begin
                                                phase_next   = PH_HINV;
                                                cmd.shift_op = SH_HEADER_INV;
                                            end
                                            PH_HINV: begin
                                                phase_next   = PH_DATA;
                                                cmd.byte_op  = IDX_CLR;
                                                cmd.shift_op = SH_MEM;
                                            end
                                            PH_DATA: begin
                                                cmd.byte_op = IDX_INC;
                                                if (stat.more_bytes) begin
                                                    cmd.shift_op = SH_MEM;
                                                end else begin
                                                    phase_next   = PH_CHECK;
                                                    cmd.shift_op = SH_CHECK;
                                                end
                                            end
                                            PH_CHECK: begin
                                                cmd.rep_op = REP_DEC;
                                                if (stat.rep_more) begin
                                                    phase_next = PH_SYNC;
                                                    cmd.pulse  = PULSE_SYNC;
                                                end else begin
                                                    phase_next = PH_END;
                                                    cmd.pulse  = PULSE_END;
                                                end
                                            end
                                            default: ;
                                        endcase
                                    end
                                end
                            endcase
                        end
                    end
                end
                MODE_LOAD: begin
                    if (busy || stat.count_full) begin
                        drop = 1'b1;
                    end else begin
                        cmd.mem_we   = 1'b1;
                        cmd.count_op = IDX_INC;
                    end
                end
                MODE_SEND: begin
                    if (busy) begin
                        drop = 1'b1;
                    end else if (!stat.count_zero) begin
                        phase_next   = PH_SYNC;
                        cmd.check_we = 1'b1;
                        cmd.rep_op   = REP_LOAD;
                        cmd.byte_op  = IDX_CLR;
                        cmd.bit_op   = IDX_CLR;
                        cmd.shift_op = SH_ZERO;
                        cmd.time_op  = T_HIGH;
                        cmd.pulse    = PULSE_SYNC;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/pwft_datapath.sv
`default_nettype none

module pwft_datapath
    import pwft_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic [BYTE_W-1:0]    in_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    output stat_t                     stat,
    output logic                      level_next
);

    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 1 << AW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;

    logic [BASE_W-1:0] base_width_reg;
    logic [REP_W-1:0]  repeat_count_reg;

    logic [CNT_W-1:0]  byte_count_reg,   byte_count_next;
    logic [BYTE_W-1:0] check_byte_reg,   check_byte_next;
    logic [REP_W-1:0]  repeats_left_reg, repeats_left_next;
    logic [CNT_W-1:0]  byte_index_reg,   byte_index_next;
    logic [BIT_W-1:0]  bit_index_reg,    bit_index_next;
    logic [BYTE_W-1:0] shift_byte_reg,   shift_byte_next;
    logic              level_high_reg;
    logic [TICK_W-1:0] ticks_left_reg,   ticks_left_next;

    logic [CNT_W-1:0]  byte_index_inc;
    logic [BYTE_W-1:0] header;
    logic [BASE_W-1:0] unit;
    logic [BASE_W-1:0] factor;

    assign byte_index_inc = byte_index_reg + CNT_W'(1);
    assign header         = HEADER_BASE | BYTE_W'(byte_count_reg);
    assign unit           = (base_width_reg == '0) ? DEFAULT_UNIT : base_width_reg;
    assign rd_addr        = cmd.rd_next ? byte_index_inc[AW-1:0] : '0;

    // store: written while idle, read one byte ahead of use
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            store_mem[byte_count_reg[AW-1:0]] <= in_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_width_reg   <= RESET_BASE;
            repeat_count_reg <= RESET_REPEAT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_WIDTH:   base_width_reg   <= cfg_data[BASE_W-1:0];
                CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cmd.shift_op)
            SH_SHL:        shift_byte_next = {shift_byte_reg[BYTE_W-2:0], 1'b0};
            SH_HEADER:     shift_byte_next = header;
            SH_HEADER_INV: shift_byte_next = ~header;
            SH_MEM:        shift_byte_next = rd_data_reg;
            SH_CHECK:      shift_byte_next = check_byte_reg;
            SH_ZERO:       shift_byte_next = '0;
            default:       shift_byte_next = shift_byte_reg;
        endcase

        case (cmd.bit_op)
            IDX_CLR: bit_index_next = '0;
            IDX_INC: bit_index_next = bit_index_reg + BIT_W'(1);
            default: bit_index_next = bit_index_reg;
        endcase

        case (cmd.byte_op)
            IDX_CLR: byte_index_next = '0;
            IDX_INC: byte_index_next = byte_index_inc;
            default: byte_index_next = byte_index_reg;
        endcase

        case (cmd.count_op)
            IDX_CLR: byte_count_next = '0;
            IDX_INC: byte_count_next = byte_count_reg + CNT_W'(1);
            default: byte_count_next = byte_count_reg;
        endcase

        check_byte_next = cmd.check_we ? in_data : check_byte_reg;

        case (cmd.rep_op)
            REP_LOAD: repeats_left_next = (repeat_count_reg == '0) ? REP_W'(1)
                                                                   : repeat_count_reg;
            REP_DEC:  repeats_left_next = (repeats_left_reg != '0)
                                          ? repeats_left_reg - REP_W'(1) : '0;
            default:  repeats_left_next = repeats_left_reg;
        endcase

        // length of the half that starts now; bit halves follow the new MSB
        if (cmd.time_op == T_HIGH) begin
            case (cmd.pulse)
                PULSE_SYNC: factor = F_SYNC_HIGH;
                PULSE_END:  factor = F_END_HIGH;
                default:    factor = shift_byte_next[BYTE_W-1] ? F_THREE : F_ONE;
            endcase
        end else begin
            case (cmd.pulse)
                PULSE_SYNC: factor = F_ONE;
                PULSE_END:  factor = F_END_LOW;
                default:    factor = shift_byte_next[BYTE_W-1] ? F_ONE : F_THREE;
            endcase
        end

        case (cmd.time_op)
            T_DEC: begin
                ticks_left_next = (ticks_left_reg != '0) ? ticks_left_reg - TICK_W'(1) : '0;
                level_next      = level_high_reg;
            end
            T_HIGH: begin
                ticks_left_next = TICK_W'(unit) * TICK_W'(factor);
                level_next      = 1'b1;
            end
            T_LOW: begin
                ticks_left_next = TICK_W'(unit) * TICK_W'(factor);
                level_next      = 1'b0;
            end
            T_STOP: begin
                ticks_left_next = '0;
                level_next      = 1'b0;
            end
            default: begin
                ticks_left_next = ticks_left_reg;
                level_next      = level_high_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            check_byte_reg   <= '0;
            repeats_left_reg <= '0;
            byte_index_reg   <= '0;
            bit_index_reg    <= '0;
            shift_byte_reg   <= '0;
            level_high_reg   <= 1'b0;
            ticks_left_reg   <= '0;
        end else begin
            byte_count_reg   <= byte_count_next;
            check_byte_reg   <= check_byte_next;
            repeats_left_reg <= repeats_left_next;
            byte_index_reg   <= byte_index_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            level_high_reg   <= level_next;
            ticks_left_reg   <= ticks_left_next;
        end
    end

    assign stat.expire     = (ticks_left_reg <= TICK_W'(1));
    assign stat.level_high = level_high_reg;
    assign stat.bit_last   = (bit_index_reg == '1);
    assign stat.more_bytes = (byte_index_inc < byte_count_reg) && (byte_index_inc < MAX_CNT);
    assign stat.rep_more   = (repeats_left_reg > REP_W'(1));
    assign stat.count_zero = (byte_count_reg == '0);
    assign stat.count_full = (byte_count_reg >= MAX_CNT);

endmodule

`default_nettype wire

### dv/pulse_width_frame_transmitter_unit_test.sv
`default_nettype none

module pulse_width_frame_transmitter_unit_test;
    import pwft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode 3 carries no meaning; the block must ignore it.
    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    // Register index outside the map; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 8'hFF;

    localparam int RAND_ITEMS   = 800;    // random frames stop past this count
    localparam int FINAL_TICKS  = 300;    // items in the closing long frame
    localparam int EXCURSION    = 120;    // ticks spent at a wide unit width
    localparam int LONG_HOLD    = 64;     // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 5_000_000;

    // One result item: pin level, frame in flight, load/send dropped.
    typedef struct packed {
        logic pin;
        logic busy;
        logic drop;
    } pin_result_t;

    // Directed script: a row is either an item or a register write. Rows
    // marked typed carry their result; the rest go through the predictor.
    typedef struct packed {
        logic                 cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [1:0]           mode;
        logic [BYTE_W-1:0]    value;
        logic                 typed;
        pin_result_t          want;    // pin/busy/drop
    } script_row_t;

    localparam int DIR_N = 23;
    localparam script_row_t DIR_TAB [DIR_N] = '{
        // after reset: idle tick, unused mode, send with empty buffer
        '{1'b0, 8'h00, MODE_TICK,   8'h00, 1'b1, 3'b000},
        '{1'b0, 8'h00, MODE_UNUSED, 8'hFF, 1'b1, 3'b000},
        '{1'b0, 8'h00, MODE_SEND,   8'hA5, 1'b1, 3'b000},
        // unmapped index, unit width 1 with high data bits set, repeat 0
        '{1'b1, CFG_UNUSED,       MODE_TICK, 8'h5A, 1'b0, 3'b000},
        '{1'b1, CFG_BASE_WIDTH,   MODE_TICK, 8'hE1, 1'b0, 3'b000},
        '{1'b1, CFG_REPEAT_COUNT, MODE_TICK, 8'h00, 1'b0, 3'b000},
        // two bytes, then send: pin goes high at once
        '{1'b0, 8'h00, MODE_LOAD,   8'h00, 1'b1, 3'b000},
        '{1'b0, 8'h00, MODE_LOAD,   8'hFF, 1'b1, 3'b000},
        '{1'b0, 8'h00, MODE_SEND,   8'h3C, 1'b1, 3'b110},
        // load and send while busy are dropped, mode 3 is not
        '{1'b0, 8'h00, MODE_LOAD,   8'h11, 1'b1, 3'b111},
        '{1'b0, 8'h00, MODE_SEND,   8'h22, 1'b1, 3'b111},
        '{1'b0, 8'h00, MODE_UNUSED, 8'h00, 1'b1, 3'b110},
        '{1'b0, 8'h00, MODE_TICK,   8'hFF, 1'b1, 3'b110},
        // further sync ticks, predicted
        '{1'b0, 8'h00, MODE_TICK,   8'h01, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h02, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h04, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h08, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h10, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h20, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h40, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h80, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'h55, 1'b0, 3'b000},
        '{1'b0, 8'h00, MODE_TICK,   8'hAA, 1'b0, 3'b000}
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_mode    = 2'd0;
    logic [BYTE_W-1:0]    s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_pin_level;
    logic                 m_busy_res;
    logic                 m_dropped;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    pulse_width_frame_transmitter_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pin_level (m_pin_level),
        .m_busy_res  (m_busy_res),
        .m_dropped   (m_dropped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run-level flags shared by the driver, the receiver and the checker.
    logic        failed        = 1'b0;
    logic        idle_on       = 1'b1;   // random gaps/stalls allowed
    logic        long_hold_req = 1'b0;   // ask the receiver for one long stall
    int          items_sent    = 0;
    pin_result_t pending_levels[$];      // results still to arrive, in order

    // ---------------------------------------------------------------
    // Frame predictor: own copy of the registers and transmitter state.
    // ---------------------------------------------------------------
    logic [BASE_W-1:0] p_base;
    logic [REP_W-1:0]  p_repeat;
    logic [BYTE_W-1:0] p_store [MAX_PAYLOAD_DEF];
    logic [CNT_W-1:0]  p_count;
    logic [BYTE_W-1:0] p_check;
    logic [REP_W-1:0]  p_reps_left;
    phase_t            p_phase;
    logic [CNT_W-1:0]  p_byte_idx;
    logic [BIT_W-1:0]  p_bit_idx;
    logic [BYTE_W-1:0] p_shift;
    logic              p_level;
    logic [TICK_W-1:0] p_ticks;

    // Start the high or low half of the current pulse. Width is read live.
    function automatic void start_half(input logic high);
        logic [TICK_W-1:0] a;
        a = (p_base == '0) ? TICK_W'(DEFAULT_UNIT) : TICK_W'(p_base);
        p_level = high;
        case (p_phase)
            PH_SYNC: p_ticks = high ? a * TICK_W'(F_SYNC_HIGH) : a;
            PH_END:  p_ticks = high ? a * TICK_W'(F_END_HIGH) : a * TICK_W'(F_END_LOW);
            // long half is high for a one bit, low for a zero bit
            default: p_ticks = (p_shift[7] == high) ? a * TICK_W'(F_THREE) : a;
        endcase
    endfunction

    function automatic pin_result_t step_frame(input logic [1:0] mode,
                                               input logic [BYTE_W-1:0] data);
        pin_result_t       r;
        logic              busy;
        logic [BYTE_W-1:0] hdr;
        busy   = (p_phase != PH_IDLE);
        hdr    = HEADER_BASE | {2'b00, p_count};   // length 32 folds into 0xA0
        r.drop = 1'b0;
        if (mode == MODE_TICK) begin
            if (busy) begin
                if (p_ticks != '0)
                    p_ticks = p_ticks - 1'b1;
                if (p_ticks == '0) begin
                    if (p_level) begin
                        start_half(1'b0);
                    end else if (p_phase == PH_SYNC) begin
                        p_phase   = PH_HEAD;
                        p_shift   = hdr;
                        p_bit_idx = '0;
                        start_half(1'b1);
                    end else if (p_phase == PH_END) begin
                        // frame done: idle, pin low, buffer emptied
                        p_phase = PH_IDLE;
                        p_level = 1'b0;
                        p_ticks = '0;
                        p_count = '0;
                    end else begin
                        p_shift   = p_shift << 1;
                        p_bit_idx = p_bit_idx + 1'b1;
                        if (p_bit_idx == '0) begin
                            case (p_phase)
                                PH_HEAD: begin
                                    p_phase = PH_HINV;
                                    p_shift = ~hdr;
                                end
                                PH_HINV: begin
                                    p_phase    = PH_DATA;
                                    p_byte_idx = '0;
                                    p_shift    = p_store[0];
                                end
                                PH_DATA: begin
                                    p_byte_idx = p_byte_idx + 1'b1;
                                    if (p_byte_idx < p_count && p_byte_idx < MAX_PAYLOAD_DEF) begin
                                        p_shift = p_store[p_byte_idx[4:0]];
                                    end else begin
                                        p_phase = PH_CHECK;
                                        p_shift = p_check;
                                    end
                                end
                                default: begin
                                    if (p_reps_left != '0)
                                        p_reps_left = p_reps_left - 1'b1;
                                    if (p_reps_left != '0)
                                        p_phase = PH_SYNC;
                                    else
                                        p_phase = PH_END;
                                end
                            endcase
                        end
                        start_half(1'b1);
                    end
                end
            end
        end else if (mode == MODE_LOAD) begin
            if (busy || p_count >= MAX_PAYLOAD_DEF) begin
                r.drop = 1'b1;
            end else begin
                p_store[p_count[4:0]] = data;
                p_count = p_count + 1'b1;
            end
        end else if (mode == MODE_SEND) begin
            if (busy) begin
                r.drop = 1'b1;
            end else if (p_count != '0) begin
                p_check     = data;
                p_reps_left = (p_repeat == '0) ? REP_W'(1) : p_repeat;
                p_byte_idx  = '0;
                p_bit_idx   = '0;
                p_shift     = '0;
                p_phase     = PH_SYNC;
                start_half(1'b1);
            end
        end
        r.pin  = p_level;
        r.busy = (p_phase != PH_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side. Payload changes at the falling edge; acceptance is
    // seen at the rising edge. Valid stays up across back-to-back items.
    // ---------------------------------------------------------------
    task automatic put_item(input logic [1:0] mode, input logic [BYTE_W-1:0] data,
                            input logic typed = 1'b0, input pin_result_t given = '0);
        pin_result_t want;
        int          gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_data  <= data;
        do @(posedge aclk); while (!s_ready);
        want = step_frame(mode, data);
        pending_levels.push_back(typed ? given : want);
        items_sent++;
    endtask

    // Register write: the input is parked and every result drained first.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [BYTE_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_BASE_WIDTH)
            p_base = value[BASE_W-1:0];
        else if (idx == CFG_REPEAT_COUNT)
            p_repeat = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready bursts, plus one long hold-off on request
    // so the output register fills and s_ready backs up.
    // ---------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Checker: each result against the oldest expectation.
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0b got %0b", $realtime, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin : result_check
        pin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: result with none pending, expected nothing got %0b%0b%0b",
                         $realtime, m_pin_level, m_busy_res, m_dropped);
                failed = 1'b1;
            end else begin
                want = pending_levels.pop_front();
                check_field("pin_level", want.pin,  m_pin_level);
                check_field("busy_res",  want.busy, m_busy_res);
                check_field("dropped",   want.drop, m_dropped);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        int                n;
        int                r;
        int                excursions;
        logic              want_excursion;
        logic              long_hold_done;
        logic [BASE_W-1:0] wide_units [3];

        wide_units     = '{5'd0, 5'd25, 5'd31};   // 0 reads as 20
        excursions     = 0;
        want_excursion = 1'b1;
        long_hold_done = 1'b0;

        // predictor at reset
        p_base      = RESET_BASE;
        p_repeat    = RESET_REPEAT;
        p_count     = '0;
        p_check     = '0;
        p_reps_left = '0;
        p_phase     = PH_IDLE;
        p_byte_idx  = '0;
        p_bit_idx   = '0;
        p_shift     = '0;
        p_level     = 1'b0;
        p_ticks     = '0;
        for (int i = 0; i < MAX_PAYLOAD_DEF; i++)
            p_store[i] = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed script
        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_TAB[i].cfg)
                write_register(DIR_TAB[i].idx, DIR_TAB[i].value);
            else
                put_item(DIR_TAB[i].mode, DIR_TAB[i].value, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // Random frames: finish the running frame with ticks and some noise,
        // then load a short buffer and send. Some frames take a detour
        // through a wide unit width while data bits are going out.
        forever begin
            while (p_phase != PH_IDLE) begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    put_item(MODE_LOAD, 8'($urandom));
                else if (r == 1)
                    put_item(MODE_SEND, 8'($urandom));
                else if (r == 2)
                    put_item(MODE_UNUSED, 8'($urandom));
                else
                    put_item(MODE_TICK, 8'($urandom));

                // fill the output register and back up the input once
                if (!long_hold_done && items_sent >= 400) begin
                    long_hold_req  = 1'b1;
                    long_hold_done = 1'b1;
                end

                if (want_excursion && p_phase == PH_DATA) begin
                    want_excursion = 1'b0;
                    write_register(CFG_BASE_WIDTH, {3'($urandom), wide_units[excursions % 3]});
                    excursions++;
                    repeat (EXCURSION) put_item(MODE_TICK, 8'($urandom));
                    write_register(CFG_BASE_WIDTH, 8'd1);
                end
            end
            if (items_sent >= RAND_ITEMS)
                break;

            idle_on        = ($urandom_range(0, 3) != 0);
            want_excursion = ($urandom_range(0, 1) == 0);
            if ($urandom_range(0, 1) == 0)
                write_register(CFG_REPEAT_COUNT, 8'($urandom_range(0, 2)));
            write_register(CFG_BASE_WIDTH,
                           {3'($urandom), ($urandom_range(0, 3) == 0) ? 5'd2 : 5'd1});

            // an empty buffer now and then: send does nothing
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            repeat (n) put_item(MODE_LOAD, 8'($urandom));
            if ($urandom_range(0, 1) == 0)
                put_item(($urandom_range(0, 1) == 0) ? MODE_UNUSED : MODE_TICK, 8'($urandom));
            put_item(MODE_SEND, 8'($urandom));
        end

        // Closing part, no idling: full buffer (header folds to 0xA0),
        // overflow loads dropped, 255 repeats. Left running at the end.
        idle_on = 1'b0;
        write_register(CFG_REPEAT_COUNT, 8'hFF);
        write_register(CFG_BASE_WIDTH, 8'd1);
        repeat (MAX_PAYLOAD_DEF + 2) put_item(MODE_LOAD, 8'($urandom));
        put_item(MODE_SEND, 8'($urandom));
        repeat (FINAL_TICKS) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                put_item(MODE_LOAD, 8'($urandom));
            else if (r == 1)
                put_item(MODE_SEND, 8'($urandom));
            else
                put_item(MODE_TICK, 8'($urandom));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #LIMIT_NS;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/pwft_pkg.sv
design/pwft_ctrl.sv
design/pwft_datapath.sv
design/pulse_width_frame_transmitter_unit.sv
dv/pulse_width_frame_transmitter_unit_test.sv
